>>> sv/aes192_block_cipher_defines.svh
// Assertion macros for the AES-192 block cipher.
// Used by the top level only; no other dependencies.
`ifndef AES192_BLOCK_CIPHER_DEFINES_SVH
`define AES192_BLOCK_CIPHER_DEFINES_SVH
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> sv/aes_pkg.sv
// Package for the AES-192 block cipher: sizes, S-boxes, round functions.
// No dependencies.
package aes_pkg;
   localparam int Rounds     = 12;
   localparam int KeyWords   = 6;
   localparam int SchedWords = 208 / 4;
   localparam int WIdxW      = $clog2(SchedWords);
   localparam int RndW       = $clog2(Rounds + 1);

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;

   typedef logic [127:0] block_type;
   typedef logic [WIdxW-1:0] widx_type;

   typedef struct packed {
      logic     rd_en;
      widx_type rd_addr;
   } key_rd_type;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
   endfunction

   // byte i of the block (i = r + 4c) sits at bits 127-8i
   function automatic logic [7:0] byte_at(input block_type b, input int i);
      return b[127-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type b, input logic inv);
      block_type o;
      int src;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? (r + 4 * ((c - r + 4) % 4)) : (r + 4 * ((c + r) % 4));
            o[127-8*(r+4*c) -: 8] = inv ? INV_BOX[byte_at(b, src)] : FWD_BOX[byte_at(b, src)];
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] a, input logic inv);
      logic [7:0] x [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [31:0] o;
      for (int k = 0; k < 4; k++) begin
         x[k]  = a[31-8*k -: 8];
         x2[k] = xt(x[k]);
         x4[k] = xt(x2[k]);
         x8[k] = xt(x4[k]);
         m2[k] = x2[k];
         m3[k] = x2[k] ^ x[k];
         m9[k] = x8[k] ^ x[k];
         mb[k] = x8[k] ^ x2[k] ^ x[k];
         md[k] = x8[k] ^ x4[k] ^ x[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      o = '0;
      for (int r = 0; r < 4; r++) begin
         if (inv) begin
            o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
         end else begin
            o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ x[(r+2)%4] ^ x[(r+3)%4];
         end
      end
      return o;
   endfunction

   function automatic block_type mix(input block_type b, input logic inv);
      block_type o;
      for (int c = 0; c < 4; c++) begin
         o[127-32*c -: 32] = mix_col(b[127-32*c -: 32], inv);
      end
      return o;
   endfunction
endpackage

>>> sv/aes_key_sched.sv
// Key schedule: expands the key registers into the round-key memory.
// One word a cycle; the memory has one write and one registered read port.
// Depends on aes_pkg.
module aes_key_sched (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [191:0]             key,
   input  aes_pkg::key_rd_type      rd,
   output logic [127:0]             rd_data,
   output logic                     busy
);
   import aes_pkg::*;

   logic [31:0] hist_ff [KeyWords];
   logic [31:0] hist_in [KeyWords];
   logic        busy_ff, busy_in;
   widx_type    idx_ff, idx_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  rc_ff, rc_in;
   logic [31:0] wr_word;
   logic [31:0] t;
   logic [31:0] rdw [4];

   // Four words a round key: store the schedule as four banks read together.
   logic [31:0] bank0 [SchedWords/4];
   logic [31:0] bank1 [SchedWords/4];
   logic [31:0] bank2 [SchedWords/4];
   logic [31:0] bank3 [SchedWords/4];

   assign busy = busy_ff;

   always_comb begin
      t = hist_ff[KeyWords-1];
      if (phase_ff == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rc_ff, 24'h0};
      end
      wr_word = hist_ff[0] ^ t;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      rc_in    = rc_ff;
      for (int i = 0; i < KeyWords; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         phase_in = '0;
         rc_in    = 8'h01;
         for (int i = 0; i < KeyWords; i++) begin
            hist_in[i] = key[191-32*i -: 32];
         end
      end else if (busy_ff) begin
         idx_in = idx_ff + widx_type'(1);
         if (idx_ff >= widx_type'(KeyWords)) begin
            for (int i = 0; i < KeyWords - 1; i++) begin
               hist_in[i] = hist_ff[i+1];
            end
            hist_in[KeyWords-1] = wr_word;
            phase_in = (phase_ff == 3'(KeyWords - 1)) ? 3'd0 : phase_ff + 3'd1;
            if (phase_ff == 3'd0) begin
               rc_in = xt(rc_ff);
            end
         end
         if (idx_ff == widx_type'(SchedWords - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // first six words are the key itself, then the expansion
   logic [31:0] mem_wdata;
   always_comb begin
      if (idx_ff < widx_type'(KeyWords)) begin
         mem_wdata = hist_ff[idx_ff[2:0]];
      end else begin
         mem_wdata = wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      phase_ff <= phase_in;
      rc_ff    <= rc_in;
      for (int i = 0; i < KeyWords; i++) begin
         hist_ff[i] <= hist_in[i];
      end
   end

   // memory write: keep the history window unshifted until the key words are stored
   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         case (idx_ff[1:0])
            2'd0: bank0[idx_ff[WIdxW-1:2]] <= mem_wdata;
            2'd1: bank1[idx_ff[WIdxW-1:2]] <= mem_wdata;
            2'd2: bank2[idx_ff[WIdxW-1:2]] <= mem_wdata;
            default: bank3[idx_ff[WIdxW-1:2]] <= mem_wdata;
         endcase
      end
      if (rd.rd_en) begin
         rdw[0] <= bank0[rd.rd_addr[WIdxW-1:2]];
         rdw[1] <= bank1[rd.rd_addr[WIdxW-1:2]];
         rdw[2] <= bank2[rd.rd_addr[WIdxW-1:2]];
         rdw[3] <= bank3[rd.rd_addr[WIdxW-1:2]];
      end
   end

   assign rd_data = {rdw[0], rdw[1], rdw[2], rdw[3]};
endmodule

>>> sv/aes_round_core.sv
// Round datapath: one AES round a cycle, round key from the schedule memory.
// Depends on aes_pkg.
module aes_round_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 decrypt,
   input  aes_pkg::block_type   blk_in,
   input  aes_pkg::block_type   rkey,
   output aes_pkg::key_rd_type  rd,
   output logic                 done,
   output aes_pkg::block_type   blk_out
);
   import aes_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;

   logic [1:0]  st_ff, st_in;
   logic [RndW-1:0] cnt_ff, cnt_in;
   logic        dec_ff;
   block_type   st_blk_ff, st_blk_in;
   block_type   pre;
   block_type   nxt;
   logic [RndW-1:0] rnd_req;

   // cnt counts rounds done; the key for round n is read in the cycle before round n
   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      st_blk_in = st_blk_ff;
      done      = 1'b0;
      rnd_req   = '0;
      pre       = st_blk_ff;
      nxt       = st_blk_ff ^ rkey;
      case (st_ff)
         ST_IDLE: begin
            rnd_req = decrypt ? RndW'(Rounds) : '0;
            if (start) begin
               st_in     = ST_RUN;
               cnt_in    = '0;
               st_blk_in = blk_in;
            end
         end
         ST_RUN: begin
            if (cnt_ff == '0) begin
               nxt = st_blk_ff ^ rkey;
            end else if (!dec_ff) begin
               pre = sub_shift(st_blk_ff, 1'b0);
               if (cnt_ff != RndW'(Rounds)) begin
                  pre = mix(pre, 1'b0);
               end
               nxt = pre ^ rkey;
            end else begin
               pre = sub_shift(st_blk_ff, 1'b1) ^ rkey;
               nxt = (cnt_ff != RndW'(Rounds)) ? mix(pre, 1'b1) : pre;
            end
            st_blk_in = nxt;
            cnt_in    = cnt_ff + RndW'(1);
            if (cnt_ff != RndW'(Rounds)) begin
               rnd_req = dec_ff ? RndW'(Rounds) - cnt_in : cnt_in;
            end
            if (cnt_ff == RndW'(Rounds)) begin
               st_in = ST_IDLE;
               done  = 1'b1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      rd.rd_en   = 1'b1;
      rd.rd_addr = widx_type'({rnd_req, 2'b00});
   end

   assign blk_out = st_blk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      if (start && st_ff == ST_IDLE) begin
         dec_ff <= decrypt;
      end
      st_blk_ff <= st_blk_in;
   end
endmodule

>>> sv/aes192_block_cipher.sv
// AES-192 ECB engine. Writing any key register re-expands the round-key memory, one word a
// cycle, with no block taken meanwhile; this also runs after reset for the zero key.
// The round register does one round a cycle, reading each round key from the schedule
// memory in the cycle before the round. A result waits in the output register while the
// next block may be taken once it is transferred.
module aes192_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import aes_pkg::*;
   `include "aes192_block_cipher_defines.svh"

   logic [63:0] key_ff [3];
   logic        kick_ff;
   logic        ks_busy;
   logic        core_busy_ff, core_busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   block_type   res_ff;
   block_type   rkey;
   block_type   core_out;
   key_rd_type  rd;
   logic        core_done;
   logic        req_xfer;

   assign csr_ready = 1'b1;
   assign req_ready = !core_busy_ff && !rsp_valid_ff && !ks_busy && !kick_ff;
   assign req_xfer  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         kick_ff   <= 1'b1;
      end else begin
         kick_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_KEY0: begin key_ff[0] <= csr_data; kick_ff <= 1'b1; end
               CSR_KEY1: begin key_ff[1] <= csr_data; kick_ff <= 1'b1; end
               CSR_KEY2: begin key_ff[2] <= csr_data; kick_ff <= 1'b1; end
               default: ;
            endcase
         end
      end
   end

   aes_key_sched u_ks (
      .clock(clock), .reset(reset), .start(kick_ff),
      .key({key_ff[0], key_ff[1], key_ff[2]}),
      .rd(rd), .rd_data(rkey), .busy(ks_busy));

   aes_round_core u_core (
      .clock(clock), .reset(reset), .start(req_xfer), .decrypt(req_type),
      .blk_in({req_block_hi, req_block_lo}), .rkey(rkey), .rd(rd),
      .done(core_done), .blk_out(core_out));

   always_comb begin
      core_busy_in = core_busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) core_busy_in = 1'b1;
      if (core_done) begin
         core_busy_in = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         core_busy_ff <= core_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (core_done) res_ff <= core_out;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_hi = res_ff[127:64];
   assign rsp_result_lo = res_ff[63:0];

   `AES_ASSERT_IMPL(a_no_overlap, clock, reset, core_busy_ff, !req_ready, "block taken while busy")
   `AES_ASSERT_IMPL(a_done_busy, clock, reset, core_done, core_busy_ff, "result without a block")
   `AES_ASSERT_IMPL(a_sched_lock, clock, reset, ks_busy, !req_xfer, "block taken during expansion")
endmodule
